[sv/rgb_contrast_stretch_unit_assert.svh]
// Assertion macros used by the checker of the contrast stretch unit.
`ifndef RGB_CONTRAST_STRETCH_UNIT_ASSERT_SVH
`define RGB_CONTRAST_STRETCH_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RCS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rgb_contrast_stretch_unit: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define RCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rgb_contrast_stretch_unit: next-cycle check failed");

`endif

[sv/rcs_pkg.sv]
package rcs_pkg;

	localparam int NUM_CH    = 3;
	localparam int DIV_STEPS = 8;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	localparam logic [7:0] FULL_SCALE = 8'd255;
	localparam logic [7:0] LOW_RESET  = 8'd255;
	localparam logic [7:0] HIGH_RESET = 8'd0;

	localparam logic KIND_MEASURE = 1'b0;
	localparam logic KIND_STRETCH = 1'b1;

	typedef struct packed {
		logic       kind;
		logic       first_of_frame;
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
	} pix_item_t;

	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
	} res_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIV,
		ST_WRITE
	} rcs_state_t;

endpackage

[sv/rgb_contrast_stretch_unit.sv]
// Per-channel min/max contrast stretch for 8-bit RGB. A measure transaction
// (kind 0) folds its pixel into the running min/max of each channel;
// first_of_frame restarts the min/max from that pixel. A stretch
// transaction (kind 1) returns floor((v-min)*255/(max-min)) per channel,
// saturated to 0 below min and 255 above max, and 0 for a flat or empty range.
// A stretch transaction is accepted, numerator and divisor are formed, then
// 8 restoring-division steps run (one quotient bit per cycle on a divide lane
// per channel) and the result register is loaded. pix_stall stays high through
// preparation, division and write, longer if the result register still holds
// an unaccepted result. Measure transactions are taken every cycle while idle.
module rgb_contrast_stretch_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pix_valid,
	output logic              pix_stall,
	input  rcs_pkg::pix_item_t pix,
	output logic              res_valid,
	input  logic              res_stall,
	output rcs_pkg::res_item_t res
);

	rcs_pkg::rcs_state_t state_q, state_d;

	logic [rcs_pkg::CNT_W-1:0] cnt_q;
	logic                      pix_acc;
	logic                      prep_en, step_en, load_res, res_free;

	logic [7:0]  low_q   [rcs_pkg::NUM_CH];
	logic [7:0]  high_q  [rcs_pkg::NUM_CH];
	logic [7:0]  ch_in   [rcs_pkg::NUM_CH];
	logic [7:0]  ch_q    [rcs_pkg::NUM_CH];
	logic [7:0]  span_q  [rcs_pkg::NUM_CH];
	logic [7:0]  rem_q   [rcs_pkg::NUM_CH];
	logic [7:0]  nq_q    [rcs_pkg::NUM_CH];
	logic        zero_q  [rcs_pkg::NUM_CH];
	logic        full_q  [rcs_pkg::NUM_CH];

	logic [7:0]  diff    [rcs_pkg::NUM_CH];
	logic [15:0] num     [rcs_pkg::NUM_CH];
	logic [7:0]  span    [rcs_pkg::NUM_CH];
	logic [8:0]  trial   [rcs_pkg::NUM_CH];
	logic [7:0]  trial_r [rcs_pkg::NUM_CH];
	logic        ge      [rcs_pkg::NUM_CH];
	logic [7:0]  lane_out[rcs_pkg::NUM_CH];

	logic              res_valid_q;
	rcs_pkg::res_item_t res_q;

	// Split the incoming pixel into channels
	assign ch_in[0] = pix.red_in;
	assign ch_in[1] = pix.green_in;
	assign ch_in[2] = pix.blue_in;

	assign pix_acc  = pix_valid && !pix_stall;
	assign res_free = !res_valid_q || !res_stall;

	// Sequencer: next state and control strobes
	always_comb begin
		state_d   = state_q;
		pix_stall = 1'b1;
		prep_en   = 1'b0;
		step_en   = 1'b0;
		load_res  = 1'b0;
		unique case (state_q)
			rcs_pkg::ST_IDLE: begin
				pix_stall = 1'b0;
				if (pix_valid && pix.kind == rcs_pkg::KIND_STRETCH) begin
					state_d = rcs_pkg::ST_PREP;
				end
			end
			rcs_pkg::ST_PREP: begin
				prep_en = 1'b1;
				state_d = rcs_pkg::ST_DIV;
			end
			rcs_pkg::ST_DIV: begin
				step_en = 1'b1;
				if (cnt_q == rcs_pkg::CNT_W'(rcs_pkg::DIV_STEPS - 1)) begin
					state_d = rcs_pkg::ST_WRITE;
				end
			end
			rcs_pkg::ST_WRITE: begin
				if (res_free) begin
					load_res = 1'b1;
					state_d  = rcs_pkg::ST_IDLE;
				end
			end
			default: state_d = rcs_pkg::ST_IDLE;
		endcase
	end

	// Per-lane datapath: numerator, divisor, one restoring step, final select
	always_comb begin
		for (int i = 0; i < rcs_pkg::NUM_CH; i++) begin
			diff[i]    = ch_q[i] - low_q[i];
			num[i]     = {diff[i], 8'd0} - {8'd0, diff[i]};
			span[i]    = high_q[i] - low_q[i];
			trial[i]   = {rem_q[i], nq_q[i][7]};
			ge[i]      = trial[i] >= {1'b0, span_q[i]};
			// the difference fits in 8 bits whenever it is kept
			trial_r[i] = trial[i][7:0] - span_q[i];
			if (zero_q[i]) begin
				lane_out[i] = 8'd0;
			end else if (full_q[i]) begin
				lane_out[i] = rcs_pkg::FULL_SCALE;
			end else begin
				lane_out[i] = nq_q[i];
			end
		end
	end

	// Sequencer state and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rcs_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (prep_en) begin
				cnt_q <= '0;
			end else if (step_en) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// Track running min/max on measure transactions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < rcs_pkg::NUM_CH; i++) begin
				low_q[i]  <= rcs_pkg::LOW_RESET;
				high_q[i] <= rcs_pkg::HIGH_RESET;
			end
		end else if (pix_acc && pix.kind == rcs_pkg::KIND_MEASURE) begin
			for (int i = 0; i < rcs_pkg::NUM_CH; i++) begin
				if (pix.first_of_frame) begin
					low_q[i]  <= ch_in[i];
					high_q[i] <= ch_in[i];
				end else begin
					if (ch_in[i] < low_q[i]) begin
						low_q[i] <= ch_in[i];
					end
					if (ch_in[i] > high_q[i]) begin
						high_q[i] <= ch_in[i];
					end
				end
			end
		end
	end

	// Capture pixel, set up and step the divide lanes
	always_ff @(posedge clk) begin
		for (int i = 0; i < rcs_pkg::NUM_CH; i++) begin
			if (pix_acc) begin
				ch_q[i] <= ch_in[i];
			end
			if (prep_en) begin
				span_q[i] <= span[i];
				rem_q[i]  <= num[i][15:8];
				nq_q[i]   <= num[i][7:0];
				zero_q[i] <= (high_q[i] <= low_q[i]) || (ch_q[i] <= low_q[i]);
				full_q[i] <= ch_q[i] >= high_q[i];
			end else if (step_en) begin
				rem_q[i] <= ge[i] ? trial_r[i] : trial[i][7:0];
				nq_q[i]  <= {nq_q[i][6:0], ge[i]};
			end
		end
	end

	// Result register: hold until the transaction is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_res) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			res_q.red_out   <= lane_out[0];
			res_q.green_out <= lane_out[1];
			res_q.blue_out  <= lane_out[2];
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

[sv/rcs_checker.sv]
`include "rgb_contrast_stretch_unit_assert.svh"

module rcs_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               pix_valid,
	input logic               pix_stall,
	input rcs_pkg::pix_item_t pix,
	input logic               res_valid,
	input logic               res_stall,
	input rcs_pkg::res_item_t res
);

	logic take_stretch;
	logic take_measure;

	// Classify the accepted pixel transaction
	assign take_stretch = pix_valid && !pix_stall && pix.kind == rcs_pkg::KIND_STRETCH;
	assign take_measure = pix_valid && !pix_stall && pix.kind == rcs_pkg::KIND_MEASURE;

	// Hold a stalled result
	`RCS_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && res_stall, res_valid && $stable(res))

	// Go busy after a stretch transaction
	`RCS_ASSERT_NEXT(a_stretch_busy, clk, arst_n, take_stretch, pix_stall)

	// Take the next pixel right after a measure transaction
	`RCS_ASSERT_NEXT(a_measure_fast, clk, arst_n, take_measure, !pix_stall)

	// Raise a result only at the end of a busy span
	`RCS_ASSERT_IMP(a_res_after_busy, clk, arst_n, $rose(res_valid), $past(pix_stall))

endmodule

bind rgb_contrast_stretch_unit rcs_checker u_rcs_checker (.*);
